### rtl/stwo_pkg.sv
package stwo_pkg;

  // operation codes on the input tuser
  typedef enum logic [2:0] {
    OP_CLEAR  = 3'd0,
    OP_LOAD   = 3'd1,
    OP_ADD    = 3'd2,
    OP_FIND   = 3'd3,
    OP_REMOVE = 3'd4
  } op_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  // sequencer states
  typedef enum logic [4:0] {
    S_IDLE,
    S_DISPATCH,
    S_LB_RD,
    S_LB_CMP,
    S_LD_CHK_RD,
    S_LD_CHK,
    S_LD_FULL,
    S_SH_RD,
    S_SH_WR,
    S_INS_WR,
    S_MERGE,
    S_BS_RD,
    S_BS_CMP,
    S_OV_SCAN,
    S_MDEL_RD,
    S_MDEL_WR,
    S_ODEL,
    S_RESP
  } state_e;

  // floor(ln n) by threshold compares, 0 below 3, at most 7
  function automatic logic [2:0] ln_limit(input logic [31:0] n);
    logic [2:0] v;
    v = 3'd0;
    if (n >= 32'd3)    v = 3'd1;
    if (n >= 32'd8)    v = 3'd2;
    if (n >= 32'd21)   v = 3'd3;
    if (n >= 32'd55)   v = 3'd4;
    if (n >= 32'd149)  v = 3'd5;
    if (n >= 32'd404)  v = 3'd6;
    if (n >= 32'd1097) v = 3'd7;
    return v;
  endfunction

endpackage

### rtl/sorted_table_with_overflow_unit.sv
// channel   dir  tdata                         tuser
// s_axis    in   [63:0] key, [127:64] payload  [2:0] operation
// m_axis    out  [63:0] found payload          [1:0] status
//
// one item at a time; s_axis_tready is high only while the sequencer is idle
// find: binary search of the main table, then on a miss a linear scan of the overflow
// load, merge and remove: main-table entries shift one at a time through the
//   key/payload memory, which has one read port and one write port
// asynchronous active-low reset empties both tables; memory needs no clearing
// a result waiting on m_axis stalls the sequencer only at its last step
module sorted_table_with_overflow_unit import stwo_pkg::*; #(
  parameter int MAIN_DEPTH     = 1024,
  parameter int OVERFLOW_DEPTH = 8,
  parameter int KEY_BITS       = 64,
  parameter int PAYLOAD_BITS   = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,   // entry_key, entry_payload
  input  logic [2:0]   s_axis_tuser,   // operation
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [63:0]  m_axis_tdata,   // found_payload
  output logic [1:0]   m_axis_tuser    // status
);

  localparam int CW  = $clog2(MAIN_DEPTH + 1);
  localparam int AW  = $clog2(MAIN_DEPTH);
  localparam int OCW = $clog2(OVERFLOW_DEPTH + 1);
  localparam int OAW = $clog2(OVERFLOW_DEPTH);
  localparam logic [2:0] LimMax = (OVERFLOW_DEPTH - 1 > 7) ? 3'd7 : 3'(OVERFLOW_DEPTH - 1);

  // main table memory, one port each way, registered read
  logic [KEY_BITS-1:0]     mem_key [MAIN_DEPTH];
  logic [PAYLOAD_BITS-1:0] mem_pay [MAIN_DEPTH];
  logic [KEY_BITS-1:0]     rd_key_q;
  logic [PAYLOAD_BITS-1:0] rd_pay_q;
  logic                    mem_we;
  logic [AW-1:0]           mem_wa, mem_ra;
  logic [KEY_BITS-1:0]     mem_wkey;
  logic [PAYLOAD_BITS-1:0] mem_wpay;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_key[mem_wa] <= mem_wkey;
      mem_pay[mem_wa] <= mem_wpay;
    end
    rd_key_q <= mem_key[mem_ra];
    rd_pay_q <= mem_pay[mem_ra];
  end

  // sequencer and datapath registers
  state_e                  state_q, state_d;
  op_e                     op_q, op_d;
  logic [KEY_BITS-1:0]     skey_q, skey_d;
  logic [PAYLOAD_BITS-1:0] spay_q, spay_d;
  logic [CW-1:0]           mc_q, mc_d, lo_q, lo_d, hi_q, hi_d, pos_q, pos_d, j_q, j_d;
  logic [OCW-1:0]          oc_q, oc_d, oi_q, oi_d;
  logic [2:0]              lim_q, lim_d;
  logic                    merge_q, merge_d;
  logic [KEY_BITS-1:0]     ov_key_q [OVERFLOW_DEPTH];
  logic [KEY_BITS-1:0]     ov_key_d [OVERFLOW_DEPTH];
  logic [PAYLOAD_BITS-1:0] ov_pay_q [OVERFLOW_DEPTH];
  logic [PAYLOAD_BITS-1:0] ov_pay_d [OVERFLOW_DEPTH];
  status_e                 rst_q, rst_d;
  logic [PAYLOAD_BITS-1:0] rpay_q, rpay_d;
  logic                    ov_q, ov_d;
  logic [1:0]              ost_q, ost_d;
  logic [63:0]             opay_q, opay_d;

  // shared probe midpoint; exact search uses hi as one past the top
  logic [CW-1:0] mid;
  logic          exact;
  assign exact = (op_q == OP_FIND) || (op_q == OP_REMOVE);
  assign mid   = lo_q + ((hi_q - lo_q - (exact ? CW'(1) : CW'(0))) >> 1);

  // limit candidates for the current and the incremented count
  logic [2:0] lim_raw_cur, lim_raw_inc, lim_cur, lim_inc;
  assign lim_raw_cur = ln_limit(32'(mc_q));
  assign lim_raw_inc = ln_limit(32'(mc_q) + 32'd1);
  assign lim_cur     = (lim_raw_cur > LimMax) ? LimMax : lim_raw_cur;
  assign lim_inc     = (lim_raw_inc > LimMax) ? LimMax : lim_raw_inc;

  // add admission
  logic [31:0] add_n;
  logic        add_merge, add_full;
  assign add_n     = 32'(oc_q) + 32'd1;
  assign add_merge = (add_n > 32'(lim_q)) || (add_n >= 32'(OVERFLOW_DEPTH));
  assign add_full  = (32'(oc_q) >= 32'(OVERFLOW_DEPTH))
                   || (add_merge && (32'(mc_q) + add_n > 32'(MAIN_DEPTH)));

  logic [OAW-1:0] oi_idx;
  assign oi_idx = oi_q[OAW-1:0];

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = ov_q;
  assign m_axis_tuser  = ost_q;
  assign m_axis_tdata  = opay_q;

  // next state and control
  always_comb begin
    state_d  = state_q;
    op_d     = op_q;
    skey_d   = skey_q;
    spay_d   = spay_q;
    mc_d     = mc_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    pos_d    = pos_q;
    j_d      = j_q;
    oc_d     = oc_q;
    oi_d     = oi_q;
    lim_d    = lim_q;
    merge_d  = merge_q;
    ov_key_d = ov_key_q;
    ov_pay_d = ov_pay_q;
    rst_d    = rst_q;
    rpay_d   = rpay_q;
    ov_d     = ov_q && !m_axis_tready;
    ost_d    = ost_q;
    opay_d   = opay_q;
    mem_we   = 1'b0;
    mem_wa   = j_q[AW-1:0];
    mem_wkey = rd_key_q;
    mem_wpay = rd_pay_q;
    mem_ra   = mid[AW-1:0];

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          op_d    = op_e'(s_axis_tuser);
          skey_d  = s_axis_tdata[KEY_BITS-1:0];
          spay_d  = s_axis_tdata[64 +: PAYLOAD_BITS];
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        rst_d   = ST_OK;
        rpay_d  = '0;
        merge_d = 1'b0;
        lo_d    = '0;
        hi_d    = mc_q;
        oi_d    = '0;
        case (op_q)
          OP_CLEAR: begin
            mc_d    = '0;
            oc_d    = '0;
            lim_d   = '0;
            state_d = S_RESP;
          end
          OP_LOAD: state_d = S_LB_RD;
          OP_ADD: begin
            if (add_full) begin
              rst_d   = ST_FULL;
              state_d = S_RESP;
            end else begin
              ov_key_d[oc_q[OAW-1:0]] = skey_q;
              ov_pay_d[oc_q[OAW-1:0]] = spay_q;
              oc_d    = OCW'(add_n);
              merge_d = add_merge;
              state_d = add_merge ? S_MERGE : S_RESP;
            end
          end
          OP_FIND, OP_REMOVE: state_d = S_BS_RD;
          default: state_d = S_RESP;
        endcase
      end
      // lower-bound search
      S_LB_RD: begin
        if (lo_q < hi_q) begin
          state_d = S_LB_CMP;
        end else begin
          pos_d   = lo_q;
          j_d     = mc_q;
          state_d = merge_q ? ((mc_q > lo_q) ? S_SH_RD : S_INS_WR) : S_LD_CHK_RD;
        end
      end
      S_LB_CMP: begin
        if (rd_key_q < skey_q) lo_d = mid + CW'(1);
        else hi_d = mid;
        state_d = S_LB_RD;
      end
      // duplicate check for load
      S_LD_CHK_RD: begin
        mem_ra  = pos_q[AW-1:0];
        state_d = (pos_q < mc_q) ? S_LD_CHK : S_LD_FULL;
      end
      S_LD_CHK: begin
        state_d = (rd_key_q == skey_q) ? S_RESP : S_LD_FULL;
      end
      S_LD_FULL: begin
        if (32'(mc_q) >= 32'(MAIN_DEPTH)) begin
          rst_d   = ST_FULL;
          state_d = S_RESP;
        end else begin
          state_d = (mc_q > pos_q) ? S_SH_RD : S_INS_WR;
        end
      end
      // open a slot by shifting entries up one at a time
      S_SH_RD: begin
        mem_ra  = AW'(j_q - CW'(1));
        state_d = S_SH_WR;
      end
      S_SH_WR: begin
        mem_we  = 1'b1;
        j_d     = j_q - CW'(1);
        state_d = (j_q - CW'(1) > pos_q) ? S_SH_RD : S_INS_WR;
      end
      S_INS_WR: begin
        mem_we   = 1'b1;
        mem_wa   = pos_q[AW-1:0];
        mem_wkey = skey_q;
        mem_wpay = spay_q;
        mc_d     = mc_q + CW'(1);
        if (merge_q) begin
          oi_d    = oi_q + OCW'(1);
          state_d = S_MERGE;
        end else begin
          lim_d   = lim_inc;
          state_d = S_RESP;
        end
      end
      // merge overflow entries in arrival order
      S_MERGE: begin
        if ((oi_q < oc_q) && (32'(mc_q) < 32'(MAIN_DEPTH))) begin
          skey_d  = ov_key_q[oi_idx];
          spay_d  = ov_pay_q[oi_idx];
          lo_d    = '0;
          hi_d    = mc_q;
          state_d = S_LB_RD;
        end else begin
          oc_d    = '0;
          lim_d   = lim_cur;
          state_d = S_RESP;
        end
      end
      // exact binary search of main
      S_BS_RD: begin
        state_d = (lo_q < hi_q) ? S_BS_CMP : S_OV_SCAN;
      end
      S_BS_CMP: begin
        if (rd_key_q < skey_q) begin
          lo_d    = mid + CW'(1);
          state_d = S_BS_RD;
        end else if (rd_key_q > skey_q) begin
          hi_d    = mid;
          state_d = S_BS_RD;
        end else if (op_q == OP_FIND) begin
          rpay_d  = rd_pay_q;
          state_d = S_RESP;
        end else begin
          j_d     = mid + CW'(1);
          state_d = S_MDEL_RD;
        end
      end
      // linear scan of overflow
      S_OV_SCAN: begin
        if (oi_q < oc_q) begin
          if (ov_key_q[oi_idx] == skey_q) begin
            if (op_q == OP_FIND) begin
              rpay_d  = ov_pay_q[oi_idx];
              state_d = S_RESP;
            end else begin
              oi_d    = oi_q + OCW'(1);
              state_d = S_ODEL;
            end
          end else begin
            oi_d = oi_q + OCW'(1);
          end
        end else begin
          rst_d   = ST_MISS;
          state_d = S_RESP;
        end
      end
      // close the gap in main
      S_MDEL_RD: begin
        mem_ra = j_q[AW-1:0];
        if (j_q < mc_q) begin
          state_d = S_MDEL_WR;
        end else begin
          mc_d    = mc_q - CW'(1);
          state_d = S_RESP;
        end
      end
      S_MDEL_WR: begin
        mem_we  = 1'b1;
        mem_wa  = AW'(j_q - CW'(1));
        j_d     = j_q + CW'(1);
        state_d = S_MDEL_RD;
      end
      // close the gap in overflow
      S_ODEL: begin
        if (oi_q < oc_q) begin
          ov_key_d[OAW'(oi_q - OCW'(1))] = ov_key_q[oi_idx];
          ov_pay_d[OAW'(oi_q - OCW'(1))] = ov_pay_q[oi_idx];
          oi_d = oi_q + OCW'(1);
        end else begin
          oc_d    = oc_q - OCW'(1);
          state_d = S_RESP;
        end
      end
      // hand the result to the output register
      S_RESP: begin
        if (!ov_q || m_axis_tready) begin
          ov_d    = 1'b1;
          ost_d   = rst_q;
          opay_d  = 64'(rpay_q);
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      mc_q    <= '0;
      oc_q    <= '0;
      lim_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      mc_q    <= mc_d;
      oc_q    <= oc_d;
      lim_q   <= lim_d;
      ov_q    <= ov_d;
    end
  end

  // working and payload registers
  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    skey_q   <= skey_d;
    spay_q   <= spay_d;
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    pos_q    <= pos_d;
    j_q      <= j_d;
    oi_q     <= oi_d;
    merge_q  <= merge_d;
    ov_key_q <= ov_key_d;
    ov_pay_q <= ov_pay_d;
    rst_q    <= rst_d;
    rpay_q   <= rpay_d;
    ost_q    <= ost_d;
    opay_q   <= opay_d;
  end

endmodule

### rtl/stwo_checker.sv
module stwo_checker import stwo_pkg::*; (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [63:0]  m_axis_tdata,
  input logic [1:0]   m_axis_tuser
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
    && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // status is one of the three codes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser == ST_OK) || (m_axis_tuser == ST_MISS)
    || (m_axis_tuser == ST_FULL))
    else $error("bad status code");

  // payload is zero unless the status is ok
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != ST_OK |-> m_axis_tdata == 64'd0)
    else $error("payload on failed operation");

  // the block is busy right after taking an item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("ready right after transfer");

endmodule

bind sorted_table_with_overflow_unit stwo_checker u_stwo_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

### bench/tb_sorted_table_with_overflow_unit.sv
module tb_sorted_table_with_overflow_unit import stwo_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TBL_DEPTH  = 1024;
  localparam int OVF_DEPTH  = 8;
  localparam int IDLE_LIMIT = 200000;
  localparam int LN_STEP [7] = '{3, 8, 21, 55, 149, 404, 1097};

  typedef struct {
    bit [2:0]  op;
    bit [63:0] key;
    bit [63:0] pay;
  } request_t;

  typedef struct {
    status_e   st;
    bit [63:0] pay;
  } reply_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata;   // entry_key, entry_payload
  logic [2:0]   s_axis_tuser;   // operation
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [63:0]  m_axis_tdata;   // found_payload
  logic [1:0]   m_axis_tuser;   // status

  sorted_table_with_overflow_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // clock, 12 ns period
  initial clk_i = 1'b0;
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // shadow copy of the table state
  bit [63:0] tbl_key [TBL_DEPTH];
  bit [63:0] tbl_pay [TBL_DEPTH];
  int        tbl_cnt;
  bit [63:0] ovf_key [OVF_DEPTH];
  bit [63:0] ovf_pay [OVF_DEPTH];
  int        ovf_cnt;
  int        ovf_lim;

  request_t  pending_q [$];
  reply_t    reply_q [$];
  bit [63:0] key_pool [40];

  int n_checked, n_mismatch, n_full, n_miss, n_sent, idle_cycles;
  bit long_hold_done;

  function automatic int ln_limit_of(int n);
    int v;
    v = 0;
    for (int i = 0; i < 7; i++)
      if (n >= LN_STEP[i]) v = i + 1;
    if (v > OVF_DEPTH - 1) v = OVF_DEPTH - 1;
    return v;
  endfunction

  function automatic int lower_pos(bit [63:0] key);
    int lo, hi, mid;
    lo = 0;
    hi = tbl_cnt;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (tbl_key[mid] < key) lo = mid + 1;
      else hi = mid;
    end
    return lo;
  endfunction

  function automatic int bsearch_tbl(bit [63:0] key);
    int lo, hi, mid;
    lo = 0;
    hi = tbl_cnt - 1;
    while (hi >= lo) begin
      mid = lo + (hi - lo) / 2;
      if (tbl_key[mid] < key) lo = mid + 1;
      else if (tbl_key[mid] > key) hi = mid - 1;
      else return mid;
    end
    return -1;
  endfunction

  function automatic int scan_ovf(bit [63:0] key);
    for (int i = 0; i < ovf_cnt; i++)
      if (ovf_key[i] == key) return i;
    return -1;
  endfunction

  function automatic void insert_tbl(int pos, bit [63:0] key, bit [63:0] pay);
    for (int j = tbl_cnt; j > pos; j--) begin
      tbl_key[j] = tbl_key[j-1];
      tbl_pay[j] = tbl_pay[j-1];
    end
    tbl_key[pos] = key;
    tbl_pay[pos] = pay;
    tbl_cnt++;
  endfunction

  // apply one operation to the shadow state, return the expected reply
  function automatic reply_t table_outcome(request_t rq);
    reply_t r;
    int pos, idx, n;
    bit merge;
    r.st  = ST_OK;
    r.pay = '0;
    case (rq.op)
      OP_CLEAR: begin
        tbl_cnt = 0;
        ovf_cnt = 0;
        ovf_lim = 0;
      end
      OP_LOAD: begin
        pos = lower_pos(rq.key);
        if (!(pos < tbl_cnt && tbl_key[pos] == rq.key)) begin
          if (tbl_cnt >= TBL_DEPTH) r.st = ST_FULL;
          else begin
            insert_tbl(pos, rq.key, rq.pay);
            ovf_lim = ln_limit_of(tbl_cnt);
          end
        end
      end
      OP_ADD: begin
        n = ovf_cnt + 1;
        merge = (n > ovf_lim) || (n >= OVF_DEPTH);
        if (ovf_cnt >= OVF_DEPTH || (merge && tbl_cnt + n > TBL_DEPTH)) begin
          r.st = ST_FULL;
        end else begin
          ovf_key[ovf_cnt] = rq.key;
          ovf_pay[ovf_cnt] = rq.pay;
          ovf_cnt = n;
          if (merge) begin
            for (int i = 0; i < ovf_cnt; i++) begin
              if (tbl_cnt >= TBL_DEPTH) break;
              insert_tbl(lower_pos(ovf_key[i]), ovf_key[i], ovf_pay[i]);
            end
            ovf_cnt = 0;
            ovf_lim = ln_limit_of(tbl_cnt);
          end
        end
      end
      OP_FIND: begin
        idx = bsearch_tbl(rq.key);
        if (idx >= 0) r.pay = tbl_pay[idx];
        else begin
          idx = scan_ovf(rq.key);
          if (idx >= 0) r.pay = ovf_pay[idx];
          else r.st = ST_MISS;
        end
      end
      OP_REMOVE: begin
        idx = bsearch_tbl(rq.key);
        if (idx >= 0) begin
          for (int j = idx + 1; j < tbl_cnt; j++) begin
            tbl_key[j-1] = tbl_key[j];
            tbl_pay[j-1] = tbl_pay[j];
          end
          tbl_cnt--;
        end else begin
          idx = scan_ovf(rq.key);
          if (idx >= 0) begin
            for (int j = idx + 1; j < ovf_cnt; j++) begin
              ovf_key[j-1] = ovf_key[j];
              ovf_pay[j-1] = ovf_pay[j];
            end
            ovf_cnt--;
          end else r.st = ST_MISS;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic queue_request(bit [2:0] op, bit [63:0] key, bit [63:0] pay);
    request_t rq;
    rq.op  = op;
    rq.key = key;
    rq.pay = pay;
    pending_q = {pending_q, rq};
  endtask

  // sender: one transfer per request, random gaps with gap-free bursts
  int  tx_gap;
  bit  tx_burst;
  always @(posedge clk_i or negedge rst_ni) begin
    reply_t   r;
    bit       fire;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
      tx_gap        = 0;
      tx_burst      = 1'b0;
    end else begin
      fire = s_axis_tvalid && s_axis_tready;
      if (fire) begin
        r = table_outcome(pending_q.pop_front());
        reply_q = {reply_q, r};
        n_sent++;
        if ($urandom_range(0, 19) == 0) tx_burst = !tx_burst;
        tx_gap = tx_burst ? 0 : $urandom_range(0, 6);
      end
      if (!s_axis_tvalid || fire) begin
        if (tx_gap > 0) begin
          tx_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_q.size() > 0) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {pending_q[0].pay, pending_q[0].key};
          s_axis_tuser  <= pending_q[0].op;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: random stalls and one long hold-off
  int rx_wait;
  always @(posedge clk_i or negedge rst_ni) begin
    reply_t e;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rx_wait       = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (reply_q.size() == 0) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("unexpected result: status %0d payload %h",
                     m_axis_tuser, m_axis_tdata);
        end else begin
          e = reply_q.pop_front();
          n_checked++;
          if (e.st == ST_FULL) n_full++;
          if (e.st == ST_MISS) n_miss++;
          if (m_axis_tuser !== e.st || m_axis_tdata !== e.pay) begin
            n_mismatch++;
            if (n_mismatch <= 10)
              $display("result %0d: expected status %0d payload %h,",
                       n_checked, e.st, e.pay,
                       " got status %0d payload %h", m_axis_tuser, m_axis_tdata);
          end
        end
        rx_wait = $urandom_range(0, 6);
        if (!long_hold_done && n_checked == 300) begin
          rx_wait = 400;
          long_hold_done = 1'b1;
        end
      end
      if (rx_wait > 0) begin
        rx_wait--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int r;
    bit [2:0] op;
    tbl_cnt = 0;
    ovf_cnt = 0;
    ovf_lim = 0;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < 40; i++) key_pool[i] = {$urandom, $urandom};

    // directed: empty table, extremes, duplicates, overflow hits, unknown ops
    queue_request(OP_FIND,   64'h0, 64'h0);
    queue_request(OP_REMOVE, '1, 64'h0);
    queue_request(OP_LOAD,   64'h0, '1);
    queue_request(OP_LOAD,   '1, 64'h0);
    queue_request(OP_LOAD,   '1, 64'h1234);
    queue_request(OP_LOAD,   64'h4d41_494e_0000_0000, 64'h5555_aaaa_5555_aaaa);
    queue_request(OP_FIND,   '1, 64'h0);
    queue_request(OP_FIND,   64'h0, 64'h0);
    queue_request(OP_ADD,    64'h4f56_4552_0000_0000, 64'haaaa_5555_aaaa_5555);
    queue_request(OP_FIND,   64'h4f56_4552_0000_0000, 64'h0);
    queue_request(OP_REMOVE, 64'h4f56_4552_0000_0000, 64'h0);
    queue_request(OP_ADD,    64'h10, 64'h1);
    queue_request(OP_ADD,    '1, 64'h2);
    queue_request(OP_FIND,   '1, 64'h0);
    queue_request(OP_REMOVE, 64'h0, 64'h0);
    queue_request(OP_REMOVE, 64'h0, 64'h0);
    queue_request(3'd5, '1, '1);
    queue_request(3'd7, '1, '1);
    queue_request(OP_CLEAR,  64'h0, 64'h0);
    queue_request(OP_FIND,   '1, 64'h0);

    // grow main with descending keys so every insert after the first shifts, then merge into it
    for (int i = 0; i < 120; i++)
      queue_request(OP_LOAD, {32'h6b65_7900, 32'(119 - i)}, {$urandom, $urandom});
    for (int i = 0; i < 8; i++)
      queue_request(OP_ADD, {32'h6b65_7a00, i}, {$urandom, $urandom});
    queue_request(OP_FIND,   {32'h6b65_7900, 32'd77}, 64'h0);
    queue_request(OP_REMOVE, {32'h6b65_7900, 32'd3}, 64'h0);
    queue_request(OP_LOAD,   64'h0, '1);
    queue_request(OP_CLEAR,  64'h0, 64'h0);

    // random mix over a small key pool so that hits are common
    for (int i = 0; i < 388; i++) begin
      r = $urandom_range(0, 99);
      if (r < 2) op = OP_CLEAR;
      else if (r < 27) op = OP_LOAD;
      else if (r < 52) op = OP_ADD;
      else if (r < 77) op = OP_FIND;
      else if (r < 95) op = OP_REMOVE;
      else op = 3'($urandom_range(5, 7));
      queue_request(op, ($urandom_range(0, 9) == 0) ? {$urandom, $urandom}
                        : key_pool[$urandom_range(0, 39)], {$urandom, $urandom});
    end

    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (pending_q.size() == 0 && reply_q.size() == 0);
    repeat (100) @(posedge clk_i);

    $display("%0d operations sent incl. a shifting table fill and merges, %0d results checked",
             n_sent, n_checked);
    $display("%0d full and %0d not-found results seen", n_full, n_miss);
    if (n_mismatch == 0 && reply_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
